@@ rtl/pbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types and codes of the P4 bitmap stream decoder.
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int DIM_BITS_DEFAULT = 16;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PIX = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;
    localparam logic [1:0] ERR_SIZE  = 2'd3;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [12:0] {
        PH_START         = 13'b0000000000001,
        PH_MAGIC_COMMENT = 13'b0000000000010,
        PH_MAGIC_SECOND  = 13'b0000000000100,
        PH_MAGIC_REST    = 13'b0000000001000,
        PH_WS_WIDTH      = 13'b0000000010000,
        PH_COMMENT_WIDTH = 13'b0000000100000,
        PH_WIDTH_DIGITS  = 13'b0000001000000,
        PH_WS_HEIGHT     = 13'b0000010000000,
        PH_COMMENT_HEIGHT= 13'b0000100000000,
        PH_HEIGHT_DIGITS = 13'b0001000000000,
        PH_COMMENT_END   = 13'b0010000000000,
        PH_DATA          = 13'b0100000000000,
        PH_DONE          = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic accept;
        logic pix_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic res_load;
        logic pix_start;
        logic pix_last;
    } dp_status_t;

endpackage

@@ rtl/pbm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_ctrl
// Handshake controller: takes bytes, sequences pixel output, owns out_valid.
// ----------------------------------------------------------------------------
module pbm_ctrl
    import pbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PIX  = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.pix_emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = slot_free;
                cmd.accept = in_valid && slot_free;
                if (cmd.accept && status.pix_start)
                begin
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                cmd.pix_emit = slot_free;
                if (slot_free && status.pix_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if ((cmd.accept && status.res_load) || cmd.pix_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/pbm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_dp
// Datapath: header parser, size registers, pixel unpacker, result register.
// ----------------------------------------------------------------------------
module pbm_dp
    import pbm_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        check_magic,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    output logic [1:0]  result_kind,
    output logic        pixel_bit,
    output logic [15:0] column,
    output logic [15:0] row,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    localparam int unsigned DimMaxInt =
        (DIM_BITS >= 16) ? 65535 : ((1 << DIM_BITS) - 1);
    localparam logic [16:0] DimMax = 17'(DimMaxInt);
    localparam logic [16:0] DimCap = DimMax + 17'd1;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [16:0] accumulate(input logic [16:0] acc,
                                               input logic [3:0]  d);
        logic [20:0] v;
        v = 21'({acc, 3'b000}) + 21'({acc, 1'b0}) + 21'(d);
        return (v > 21'(DimCap)) ? DimCap : v[16:0];
    endfunction

    phase_t      phase_reg, phase_next, eff_phase;
    logic [16:0] acc_reg, acc_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] col_reg;
    logic [15:0] row_reg;
    logic        failed_reg, failed_next;
    logic        check_magic_reg;
    logic [7:0]  pix_byte_reg;
    logic [2:0]  pix_idx_reg;

    logic        res_load;
    logic [1:0]  res_kind;
    logic [1:0]  res_err;
    logic [15:0] res_col;
    logic [15:0] res_row;
    logic        pix_start;
    logic        hdr_done;
    logic [15:0] hdr_height;
    logic        end_of_row;

    // header parse of the byte on the input; also flags a truncated stream (mode) and the start of a data byte
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        failed_next = failed_reg;
        res_load    = 1'b0;
        res_kind    = KIND_HDR;
        res_err     = ERR_NONE;
        res_col     = '0;
        res_row     = '0;
        pix_start   = 1'b0;
        hdr_done    = 1'b0;
        hdr_height  = height_reg;
        eff_phase   = (phase_reg == PH_START && !check_magic_reg) ? PH_WS_WIDTH : phase_reg;

        if (!failed_reg)
        begin
            if (mode)
            begin
                if (phase_reg != PH_DONE)
                begin
                    res_load    = 1'b1;
                    res_kind    = KIND_ERR;
                    res_err     = ERR_TRUNC;
                    failed_next = 1'b1;
                end
            end
            else
            begin
                phase_next = eff_phase;
                unique case (eff_phase)
                    PH_START:
                    begin
                        if (byte_value == CH_HASH)
                        begin
                            phase_next = PH_MAGIC_COMMENT;
                        end
                        else if (byte_value == CH_P)
                        begin
                            phase_next = PH_MAGIC_SECOND;
                        end
                        else
                        begin
                            res_err = ERR_MAGIC;
                        end
                    end
                    PH_MAGIC_COMMENT:
                    begin
                        if (byte_value == CH_LF)
                        begin
                            phase_next = PH_START;
                        end
                    end
                    PH_MAGIC_SECOND:
                    begin
                        if (byte_value == CH_4)
                        begin
                            phase_next = PH_MAGIC_REST;
                        end
                        else
                        begin
                            res_err = ERR_MAGIC;
                        end
                    end
                    PH_MAGIC_REST:
                    begin
                        if (byte_value == CH_LF)
                        begin
                            phase_next = PH_WS_WIDTH;
                        end
                    end
                    PH_WS_WIDTH, PH_WS_HEIGHT:
                    begin
                        if (is_ws(byte_value))
                        begin
                            phase_next = eff_phase;
                        end
                        else if (byte_value == CH_HASH)
                        begin
                            phase_next = (eff_phase == PH_WS_WIDTH) ?
                                         PH_COMMENT_WIDTH : PH_COMMENT_HEIGHT;
                        end
                        else if (!is_digit(byte_value))
                        begin
                            res_err = ERR_MAGIC;
                        end
                        else
                        begin
                            acc_next   = accumulate(17'd0, byte_value[3:0]);
                            phase_next = (eff_phase == PH_WS_WIDTH) ?
                                         PH_WIDTH_DIGITS : PH_HEIGHT_DIGITS;
                        end
                    end
                    PH_COMMENT_WIDTH:
                    begin
                        if (byte_value == CH_LF)
                        begin
                            phase_next = PH_WS_WIDTH;
                        end
                    end
                    PH_COMMENT_HEIGHT:
                    begin
                        if (byte_value == CH_LF)
                        begin
                            phase_next = PH_WS_HEIGHT;
                        end
                    end
                    PH_WIDTH_DIGITS, PH_HEIGHT_DIGITS:
                    begin
                        if (is_digit(byte_value))
                        begin
                            acc_next = accumulate(acc_reg, byte_value[3:0]);
                        end
                        else if (!is_ws(byte_value) && byte_value != CH_HASH)
                        begin
                            res_err = ERR_MAGIC;
                        end
                        else if (acc_reg > DimMax)
                        begin
                            res_err = ERR_SIZE;
                        end
                        else if (eff_phase == PH_WIDTH_DIGITS)
                        begin
                            width_next = acc_reg[15:0];
                            acc_next   = '0;
                            phase_next = (byte_value == CH_HASH) ?
                                         PH_COMMENT_HEIGHT : PH_WS_HEIGHT;
                        end
                        else
                        begin
                            height_next = acc_reg[15:0];
                            acc_next    = '0;
                            if (byte_value == CH_HASH)
                            begin
                                phase_next = PH_COMMENT_END;
                            end
                            else
                            begin
                                hdr_done   = 1'b1;
                                hdr_height = acc_reg[15:0];
                            end
                        end
                    end
                    PH_COMMENT_END:
                    begin
                        if (byte_value == CH_LF)
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        pix_start = 1'b1;
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase

                if (res_err != ERR_NONE)
                begin
                    res_load    = 1'b1;
                    res_kind    = KIND_ERR;
                    failed_next = 1'b1;
                    phase_next  = phase_reg;
                end
                else if (hdr_done)
                begin
                    res_load   = 1'b1;
                    res_kind   = KIND_HDR;
                    res_col    = width_reg;
                    res_row    = hdr_height;
                    phase_next = (width_reg == '0 || hdr_height == '0) ? PH_DONE : PH_DATA;
                end
            end
        end
    end

    assign end_of_row = (col_reg == width_reg - 16'd1);

    assign status.res_load  = res_load;
    assign status.pix_start = pix_start;
    assign status.pix_last  = (pix_idx_reg == 3'd7) || end_of_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            acc_reg         <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            failed_reg      <= 1'b0;
            check_magic_reg <= 1'b1;
            pix_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                check_magic_reg <= check_magic;
            end
            if (cmd.accept)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                failed_reg  <= failed_next;
                pix_idx_reg <= '0;
                if (hdr_done && res_err == ERR_NONE)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            else if (cmd.pix_emit)
            begin
                pix_idx_reg <= pix_idx_reg + 3'd1;
                if (end_of_row)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 16'd1;
                    if (row_reg == height_reg - 16'd1)
                    begin
                        phase_reg <= PH_DONE;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && pix_start)
        begin
            pix_byte_reg <= byte_value;
        end
        else if (cmd.pix_emit)
        begin
            pix_byte_reg <= {pix_byte_reg[6:0], 1'b0};
        end

        if (cmd.accept && res_load)
        begin
            result_kind <= res_kind;
            pixel_bit   <= 1'b0;
            column      <= res_col;
            row         <= res_row;
            error_code  <= res_err;
            last_of_run <= 1'b1;
        end
        else if (cmd.pix_emit)
        begin
            result_kind <= KIND_PIX;
            pixel_bit   <= pix_byte_reg[7];
            column      <= col_reg;
            row         <= row_reg;
            error_code  <= ERR_NONE;
            last_of_run <= status.pix_last;
        end
    end

endmodule

@@ rtl/pbm_p4_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_p4_stream_decoder
// Binary PBM (P4) byte-stream decoder: header parse, then pixel unpacking.
// Header bytes: one per cycle unless out_ready stalls; a header or error
// result shows in the cycle after acceptance. Data byte: shifted from its
// register to the single result register, one pixel per cycle if unstalled.
// Reset: rst_n asynchronous active low, returns to start of file, magic on.
// ----------------------------------------------------------------------------
module pbm_p4_stream_decoder
    import pbm_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        check_magic,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic        pixel_bit,
    output logic [15:0] column,
    output logic [15:0] row,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pbm_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .check_magic (check_magic),
        .mode        (mode),
        .byte_value  (byte_value),
        .cmd         (cmd),
        .status      (status),
        .result_kind (result_kind),
        .pixel_bit   (pixel_bit),
        .column      (column),
        .row         (row),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

@@ rtl/pbm_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_chk
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pbm_chk
    import pbm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic        pixel_bit,
    input logic [15:0] column,
    input logic [15:0] row,
    input logic [1:0]  error_code,
    input logic        last_of_run
);

    // stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(pixel_bit) && $stable(column) && $stable(row)
            && $stable(error_code) && $stable(last_of_run))
        else $error("result changed while stalled");

    // no new byte while a byte still has pixels to send
    a_no_take_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_PIX && !last_of_run |-> !in_ready)
        else $error("input taken mid pixel run");

    // header and error results are single
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_PIX |-> last_of_run && !pixel_bit)
        else $error("header or error result not last");

    // error results carry a code and zero position
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_ERR
            |-> error_code != ERR_NONE && column == 16'd0 && row == 16'd0)
        else $error("bad error result");

    // only errors carry a code
    a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_ERR |-> error_code == ERR_NONE)
        else $error("code on non-error result");

endmodule

bind pbm_p4_stream_decoder pbm_chk u_pbm_chk (.*);
